// ===== rtl/dai_pkg.sv =====
// shared types, widths, register indexes and reset values for the alarm interlock
`timescale 1ns / 1ps

package dai_pkg;

    localparam int TIME_W  = 32;
    localparam int MS_W    = 16;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 16;
    localparam int IN_W    = 40;   // 35 payload bits padded to whole bytes
    localparam int OUT_W   = 8;    // 4 payload bits padded to whole bytes

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [MS_W-1:0]    ms_t;
    typedef logic [CIDX_W-1:0]  cidx_t;
    typedef logic [CDATA_W-1:0] cdata_t;

    // configuration register indexes
    localparam cidx_t CFG_DEBOUNCE_ENABLE = 8'd0;
    localparam cidx_t CFG_DEBOUNCE_MS     = 8'd1;
    localparam cidx_t CFG_RFID_TIMEOUT_MS = 8'd2;
    localparam cidx_t CFG_SERVO_PULSE_MS  = 8'd3;

    // register reset values
    localparam logic RST_DEBOUNCE_ENABLE = 1'b1;
    localparam ms_t  RST_DEBOUNCE_MS     = 16'd50;
    localparam ms_t  RST_RFID_TIMEOUT_MS = 16'd2000;
    localparam ms_t  RST_SERVO_PULSE_MS  = 16'd500;

    // debounce settings shared by both debounce stages
    typedef struct packed {
        logic enable;
        ms_t  hold_ms;
    } dbc_cfg_t;

endpackage

// ===== rtl/dai_debounce.sv =====
// one debounce stage: raw level tracking, change timestamp and stable level
`timescale 1ns / 1ps

module dai_debounce (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           update,
    input  logic           raw,
    input  dai_pkg::time_t now_ms,
    input  dai_pkg::dbc_cfg_t cfg,
    output logic           stable_next
);
    import dai_pkg::*;

    logic  last_raw_reg;
    time_t change_time_reg;
    logic  stable_reg;
    time_t change_time_next;
    time_t elapsed;

    always_comb
    begin
        change_time_next = (raw != last_raw_reg) ? now_ms : change_time_reg;
        elapsed          = now_ms - change_time_next;
        if (!cfg.enable)
        begin
            stable_next = raw;
        end
        else if (elapsed > {{(TIME_W-MS_W){1'b0}}, cfg.hold_ms})
        begin
            stable_next = raw;
        end
        else
        begin
            stable_next = stable_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg    <= 1'b0;
            change_time_reg <= '0;
            stable_reg      <= 1'b0;
        end
        else if (update)
        begin
            last_raw_reg    <= raw;
            change_time_reg <= change_time_next;
            stable_reg      <= stable_next;
        end
    end

endmodule

// ===== rtl/debounced_alarm_interlock_core.sv =====
// top level: debounced emergency interlock with motion, rfid and servo outputs
// datapath: a sample accepted into the input register moves on to the result register
//   once the result slot is free, and its result is then offered on the result port
// throughput: one sample per cycle, set by the single compare pass between the
//   input register and the result register, held only by output back-pressure
// reset: rst_n clears all tracking state and loads the register defaults
`timescale 1ns / 1ps

module debounced_alarm_interlock_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] now_ms, [32] emergency_raw, [33] motion_raw, [34] rfid_raw
    input  logic [dai_pkg::IN_W-1:0]       s_axis_tdata,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] motion_out, [1] rfid_out, [2] servo_out, [3] alarm_active
    output logic [dai_pkg::OUT_W-1:0]      m_axis_tdata,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  dai_pkg::cidx_t                 cfg_index,
    input  dai_pkg::cdata_t                cfg_data
);
    import dai_pkg::*;

    // configuration registers
    logic  debounce_enable_reg;
    ms_t   debounce_ms_reg;
    ms_t   rfid_timeout_ms_reg;
    ms_t   servo_pulse_ms_reg;
    dbc_cfg_t dbc_cfg;

    // input register
    logic  s1_valid_reg;
    time_t s1_now_reg;
    logic  s1_em_reg;
    logic  s1_mo_reg;
    logic  s1_rf_reg;

    // interlock state
    logic  alarm_flag_reg;
    logic  rfid_flag_reg;
    time_t rfid_high_time_reg;
    time_t servo_start_reg;

    // result register
    logic  out_valid_reg;
    logic [3:0] out_bits_reg;

    logic  advance;
    logic  in_take;
    logic  alarm_stable_next;
    logic  motion_stable_next;
    logic  motion_update;
    logic  alarm_rise;
    logic  rfid_flag_next;
    time_t rfid_high_time_next;
    time_t servo_start_next;
    time_t rfid_elapsed;
    time_t servo_elapsed;
    logic  servo_bit;
    logic [3:0] out_bits_next;

    // config port never stalls; writes are expected only while no request is in flight
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_enable_reg <= RST_DEBOUNCE_ENABLE;
            debounce_ms_reg     <= RST_DEBOUNCE_MS;
            rfid_timeout_ms_reg <= RST_RFID_TIMEOUT_MS;
            servo_pulse_ms_reg  <= RST_SERVO_PULSE_MS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_ENABLE: debounce_enable_reg <= cfg_data[0];
                CFG_DEBOUNCE_MS:     debounce_ms_reg     <= cfg_data;
                CFG_RFID_TIMEOUT_MS: rfid_timeout_ms_reg <= cfg_data;
                CFG_SERVO_PULSE_MS:  servo_pulse_ms_reg  <= cfg_data;
                default:             ;  // unknown index is dropped
            endcase
        end
    end

    assign dbc_cfg.enable  = debounce_enable_reg;
    assign dbc_cfg.hold_ms = debounce_ms_reg;

    // handshake: the input register moves on whenever the result slot frees up
    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_now_reg <= s_axis_tdata[TIME_W-1:0];
            s1_em_reg  <= s_axis_tdata[TIME_W];
            s1_mo_reg  <= s_axis_tdata[TIME_W+1];
            s1_rf_reg  <= s_axis_tdata[TIME_W+2];
        end
    end

    // emergency debounce runs on every request
    dai_debounce u_alarm_dbc (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (advance),
        .raw         (s1_em_reg),
        .now_ms      (s1_now_reg),
        .cfg         (dbc_cfg),
        .stable_next (alarm_stable_next)
    );

    // motion tracking is frozen while the alarm is latched
    assign motion_update = advance && !alarm_stable_next;

    dai_debounce u_motion_dbc (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (motion_update),
        .raw         (s1_mo_reg),
        .now_ms      (s1_now_reg),
        .cfg         (dbc_cfg),
        .stable_next (motion_stable_next)
    );

    // the alarm flag simply follows the stable emergency level
    assign alarm_rise = alarm_stable_next && !alarm_flag_reg;

    always_comb
    begin
        rfid_flag_next      = rfid_flag_reg;
        rfid_high_time_next = rfid_high_time_reg;
        servo_start_next    = servo_start_reg;
        rfid_elapsed        = s1_now_reg - rfid_high_time_reg;
        servo_bit           = 1'b0;
        if (!alarm_stable_next)
        begin
            // normal operation: rfid sets on a high sample, clears after the timeout
            if (s1_rf_reg)
            begin
                rfid_high_time_next = s1_now_reg;
                rfid_flag_next      = 1'b1;
            end
            else if (rfid_flag_reg &&
                     (rfid_elapsed >= {{(TIME_W-MS_W){1'b0}}, rfid_timeout_ms_reg}))
            begin
                rfid_flag_next = 1'b0;
            end
        end
        else if (alarm_rise)
        begin
            // alarm start: restart the servo pulse and drop rfid activity
            servo_start_next = s1_now_reg;
            rfid_flag_next   = 1'b0;
        end
        servo_elapsed = s1_now_reg - servo_start_next;
        if (alarm_stable_next)
        begin
            servo_bit = (servo_elapsed >= {{(TIME_W-MS_W){1'b0}}, servo_pulse_ms_reg});
        end
    end

    // motion and rfid outputs are forced low while the alarm is latched
    assign out_bits_next = {alarm_stable_next,
                            servo_bit,
                            !alarm_stable_next && rfid_flag_next,
                            !alarm_stable_next && motion_stable_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_flag_reg     <= 1'b0;
            rfid_flag_reg      <= 1'b0;
            rfid_high_time_reg <= '0;
            servo_start_reg    <= '0;
        end
        else if (advance)
        begin
            alarm_flag_reg     <= alarm_stable_next;
            rfid_flag_reg      <= rfid_flag_next;
            rfid_high_time_reg <= rfid_high_time_next;
            servo_start_reg    <= servo_start_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_bits_reg <= out_bits_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-4){1'b0}}, out_bits_reg};

endmodule
